/* rtl/core/lrht_pkg.sv */
// ----------------------------------------------------------------------------
// lrht_pkg
// shared types and constants of the layered region hit test unit
// ----------------------------------------------------------------------------
package lrht_pkg;

    // table sizes
    localparam int LAYERS  = 16;
    localparam int RECTS   = 8;
    localparam int LAYER_W = $clog2(LAYERS);
    localparam int RECT_W  = $clog2(RECTS);
    localparam int COUNT_W = $clog2(RECTS + 1);
    localparam int ADDR_W  = LAYER_W + RECT_W;

    // fixed field widths
    localparam int COORD_W = 16;
    localparam int EXT_W   = COORD_W + 1;
    localparam int SLOT_W  = 4;
    localparam int RSLOT_W = 3;
    localparam int CNT_FW  = 4;

    // request modes
    localparam logic [1:0] MODE_WR_LAYER = 2'd0;
    localparam logic [1:0] MODE_WR_RECT  = 2'd1;
    localparam logic [1:0] MODE_QUERY    = 2'd2;

    typedef struct packed {
        logic [1:0]                 mode;
        logic [SLOT_W-1:0]          layer_slot;
        logic [RSLOT_W-1:0]         rect_slot;
        logic                       visible;
        logic signed [COORD_W-1:0]  min_x;
        logic signed [COORD_W-1:0]  min_y;
        logic signed [COORD_W-1:0]  max_x;
        logic signed [COORD_W-1:0]  max_y;
        logic [CNT_FW-1:0]          rect_count;
        logic signed [COORD_W-1:0]  point_x;
        logic signed [COORD_W-1:0]  point_y;
    } lrht_req_t;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] hit_layer;
    } lrht_rsp_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
    } box_t;

    // one point against one inclusive box, all in extended width
    typedef struct packed {
        logic signed [EXT_W-1:0] pt_x;
        logic signed [EXT_W-1:0] pt_y;
        logic signed [EXT_W-1:0] lo_x;
        logic signed [EXT_W-1:0] lo_y;
        logic signed [EXT_W-1:0] hi_x;
        logic signed [EXT_W-1:0] hi_y;
    } cmp_op_t;

endpackage

/* rtl/core/lrht_contain.sv */
// ----------------------------------------------------------------------------
// lrht_contain
// shared containment unit: tests one point against one inclusive box
// ----------------------------------------------------------------------------
module lrht_contain
    import lrht_pkg::*;
(
    input  cmp_op_t op,
    output logic    contains
);

    // an inverted box fails one of the pairs and contains nothing
    assign contains = (op.pt_x >= op.lo_x) && (op.pt_x <= op.hi_x)
                   && (op.pt_y >= op.lo_y) && (op.pt_y <= op.hi_y);

endmodule

/* rtl/core/layered_region_hit_test_unit.sv */
// ----------------------------------------------------------------------------
// layered_region_hit_test_unit
// front-to-back window layer table with point hit test
// ----------------------------------------------------------------------------
//
//  channel | signals                    | direction | payload
//  --------+----------------------------+-----------+-----------------------
//  request | req_valid, req_stall, req  | in        | lrht_req_t
//  result  | rsp_valid, rsp_stall, rsp  | out       | lrht_rsp_t (queries only)
//
//  layer and rectangle writes produce no result
//  a query scans layers front to back through one shared containment unit:
//  a box test per layer, then a test per rectangle of a layer whose box
//  contains the point, up to the first hit, then the load of the result
//  register, which waits while that register is full and stalled; the
//  rectangles go one at a time through the memory's single read port
//  req_stall is high for the whole scan; writes are accepted while a
//  finished result still waits in the output register
//  reset clears visible flags and rectangle counts; boxes and rectangles
//  hold whatever they held until written
//
module layered_region_hit_test_unit
    import lrht_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  lrht_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output lrht_rsp_t rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BOX,
        ST_RECT,
        ST_FINISH
    } state_t;

    // sequencer state
    state_t                     state_reg, state_next;
    logic [LAYER_W-1:0]         layer_reg, layer_next;
    logic [RECT_W-1:0]          rect_reg, rect_next;
    logic signed [COORD_W-1:0]  px_reg, px_next;
    logic signed [COORD_W-1:0]  py_reg, py_next;
    logic signed [EXT_W-1:0]    ox_reg, ox_next;
    logic signed [EXT_W-1:0]    oy_reg, oy_next;
    logic                       hit_reg, hit_next;
    logic [LAYER_W-1:0]         hit_layer_reg, hit_layer_next;

    // result register
    logic                       rsp_valid_reg, rsp_valid_next;
    lrht_rsp_t                  rsp_reg, rsp_next;

    // layer table
    logic                       vis_reg [LAYERS];
    logic [COUNT_W-1:0]         cnt_reg [LAYERS];
    box_t                       box_reg [LAYERS];

    // rectangle memory, one read port with registered data
    box_t                       rect_mem [LAYERS*RECTS];
    box_t                       rd_data_reg;
    logic [RECT_W-1:0]          rd_rect;
    logic [ADDR_W-1:0]          rd_addr;

    logic                       req_acc;
    logic                       wr_layer;
    logic                       wr_rect;
    logic [COUNT_W-1:0]         wr_cnt;
    box_t                       wr_box;
    box_t                       cur_box;
    cmp_op_t                    cmp_op;
    logic                       contains;
    logic                       last_layer;
    logic                       last_rect;
    logic                       rsp_free;

    // ---------------- request side ----------------

    assign req_stall = (state_reg != ST_IDLE);
    assign req_acc   = req_valid && !req_stall;

    // out-of-range slots are dropped
    assign wr_layer = req_acc && (req.mode == MODE_WR_LAYER)
                   && (32'(req.layer_slot) < LAYERS);
    assign wr_rect  = req_acc && (req.mode == MODE_WR_RECT)
                   && (32'(req.layer_slot) < LAYERS)
                   && (32'(req.rect_slot) < RECTS);

    // counts above the table depth saturate
    assign wr_cnt = (32'(req.rect_count) > RECTS) ? COUNT_W'(RECTS)
                                                  : COUNT_W'(req.rect_count);

    assign wr_box = '{x0: req.min_x, y0: req.min_y, x1: req.max_x, y1: req.max_y};

    // ---------------- shared containment unit ----------------

    assign cur_box = box_reg[layer_reg];

    always_comb
    begin
        if (state_reg == ST_RECT)
        begin
            // point offset against a box-relative rectangle
            cmp_op.pt_x = ox_reg;
            cmp_op.pt_y = oy_reg;
            cmp_op.lo_x = EXT_W'(rd_data_reg.x0);
            cmp_op.lo_y = EXT_W'(rd_data_reg.y0);
            cmp_op.hi_x = EXT_W'(rd_data_reg.x1);
            cmp_op.hi_y = EXT_W'(rd_data_reg.y1);
        end
        else
        begin
            // point against the layer bounding box
            cmp_op.pt_x = EXT_W'(px_reg);
            cmp_op.pt_y = EXT_W'(py_reg);
            cmp_op.lo_x = EXT_W'(cur_box.x0);
            cmp_op.lo_y = EXT_W'(cur_box.y0);
            cmp_op.hi_x = EXT_W'(cur_box.x1);
            cmp_op.hi_y = EXT_W'(cur_box.y1);
        end
    end

    lrht_contain u_contain
    (
        .op       (cmp_op),
        .contains (contains)
    );

    // ---------------- sequencer ----------------

    assign last_layer = (layer_reg == LAYER_W'(LAYERS - 1));
    assign last_rect  = ((COUNT_W'(rect_reg) + COUNT_W'(1)) == cnt_reg[layer_reg]);
    assign rsp_free   = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next     = state_reg;
        layer_next     = layer_reg;
        rect_next      = rect_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        hit_next       = hit_reg;
        hit_layer_next = hit_layer_reg;
        rd_rect        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc && (req.mode == MODE_QUERY))
                begin
                    px_next    = req.point_x;
                    py_next    = req.point_y;
                    layer_next = '0;
                    state_next = ST_BOX;
                end
            end

            ST_BOX:
            begin
                // offset from the box corner, used if rectangles follow
                ox_next   = EXT_W'(px_reg) - EXT_W'(cur_box.x0);
                oy_next   = EXT_W'(py_reg) - EXT_W'(cur_box.y0);
                rect_next = '0;
                rd_rect   = '0;
                if (vis_reg[layer_reg] && contains)
                begin
                    if (cnt_reg[layer_reg] == '0)
                    begin
                        // no rectangles: the whole box counts
                        hit_next       = 1'b1;
                        hit_layer_next = layer_reg;
                        state_next     = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_RECT;
                    end
                end
                else if (last_layer)
                begin
                    hit_next       = 1'b0;
                    hit_layer_next = '0;
                    state_next     = ST_FINISH;
                end
                else
                begin
                    layer_next = layer_reg + LAYER_W'(1);
                end
            end

            ST_RECT:
            begin
                // prefetch the following rectangle
                rd_rect = rect_reg + RECT_W'(1);
                if (contains)
                begin
                    hit_next       = 1'b1;
                    hit_layer_next = layer_reg;
                    state_next     = ST_FINISH;
                end
                else if (last_rect)
                begin
                    if (last_layer)
                    begin
                        hit_next       = 1'b0;
                        hit_layer_next = '0;
                        state_next     = ST_FINISH;
                    end
                    else
                    begin
                        layer_next = layer_reg + LAYER_W'(1);
                        state_next = ST_BOX;
                    end
                end
                else
                begin
                    rect_next = rect_reg + RECT_W'(1);
                end
            end

            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_addr = {layer_reg, rd_rect};

    // ---------------- result register ----------------

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if ((state_reg == ST_FINISH) && rsp_free)
        begin
            rsp_valid_next    = 1'b1;
            rsp_next.hit       = hit_reg;
            rsp_next.hit_layer = SLOT_W'(hit_layer_reg);
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------- state and registered outputs ----------------

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            layer_reg     <= '0;
            rect_reg      <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            hit_reg       <= 1'b0;
            hit_layer_reg <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            for (int i = 0; i < LAYERS; i++)
            begin
                vis_reg[i] <= 1'b0;
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            layer_reg     <= layer_next;
            rect_reg      <= rect_next;
            px_reg        <= px_next;
            py_reg        <= py_next;
            ox_reg        <= ox_next;
            oy_reg        <= oy_next;
            hit_reg       <= hit_next;
            hit_layer_reg <= hit_layer_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
            if (wr_layer)
            begin
                vis_reg[req.layer_slot[LAYER_W-1:0]] <= req.visible;
                cnt_reg[req.layer_slot[LAYER_W-1:0]] <= wr_cnt;
            end
        end
    end

    // ---------------- box table and rectangle memory ----------------

    always_ff @(posedge clk)
    begin
        if (wr_layer)
        begin
            box_reg[req.layer_slot[LAYER_W-1:0]] <= wr_box;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_rect)
        begin
            rect_mem[{req.layer_slot[LAYER_W-1:0], req.rect_slot[RECT_W-1:0]}] <= wr_box;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= rect_mem[rd_addr];
    end

    // ---------------- assertions ----------------

    // a rectangle scan only runs on a layer that has rectangles
    a_rect_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RECT) |-> (cnt_reg[layer_reg] != '0))
        else $error("rectangle scan on a layer without rectangles");

    // the rectangle index stays below the layer's count
    a_rect_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RECT) |-> (COUNT_W'(rect_reg) < cnt_reg[layer_reg]))
        else $error("rectangle index beyond layer count");

    // a finished query with a free output register produces a result
    a_finish_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && !rsp_valid_reg) |=>
            (rsp_valid_reg && (state_reg == ST_IDLE)))
        else $error("finished query did not load the result");

    // a miss always reports layer zero
    a_miss_layer: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.hit) |-> (rsp_reg.hit_layer == '0))
        else $error("miss reported with nonzero layer");

    // no new request while a scan is running
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_BOX) || (state_reg == ST_RECT)) |-> !req_acc)
        else $error("request accepted during scan");

endmodule
